// ===== sv/icmp_rm_pkg.sv =====
// icmp reply matcher package: widths, icmp type codes, status codes,
// configuration register indexes and the result record
// no dependencies
`default_nettype none

package icmp_rm_pkg;

    localparam int MAX_PACKET_BYTES = 1024;
    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [POS_W-1:0] ICMP_HDR_LEN = POS_W'(8);

    localparam logic [2:0] ST_ECHO_MATCH    = 3'd0;
    localparam logic [2:0] ST_TTL_MATCH     = 3'd1;
    localparam logic [2:0] ST_TOO_SHORT     = 3'd2;
    localparam logic [2:0] ST_OTHER_TYPE    = 3'd3;
    localparam logic [2:0] ST_MISMATCH      = 3'd4;
    localparam logic [2:0] ST_INNER_TRUNC   = 3'd5;

    localparam logic [1:0] CFG_EXPECTED_ID  = 2'd0;
    localparam logic [1:0] CFG_EXPECTED_SEQ = 2'd1;
    localparam logic [1:0] CFG_SEND_TICK    = 2'd2;

    typedef struct packed {
        logic [31:0] round_trip;
        logic [31:0] source_addr;
        logic [2:0]  status;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/icmp_reply_matcher_top.sv =====
// icmp reply matcher top level: parses one received ipv4 packet a byte at a time
// and reports match status, source address and round-trip time per packet
// depends on icmp_rm_pkg
`default_nettype none

// Takes one packet byte per cycle, IP header first, with tlast on the final byte.
// Each byte is handled in the cycle it is accepted: offset compares against the
// current position place the header length, source address, ICMP type, inner
// header length and id/seq into registers. The result for a packet is registered
// into the output entry when its last byte is accepted, unless an earlier result
// is still waiting on m_tready. Results pass through a two-entry output buffer,
// so bytes keep flowing at one per cycle while a result waits; s_tready drops
// only when both entries are full. Bytes beyond MAX_PACKET_BYTES are accepted
// and ignored. Configuration registers should be written through cfg_wr_en, cfg_index
// and cfg_wdata only while no packet is in flight; the block itself does not enforce this.

module icmp_reply_matcher_top
    import icmp_rm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // packet_byte [7:0], tick_now [39:8]
    input  wire logic        s_tlast,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // status [2:0], source_addr [34:3],
                                        // round_trip [66:35], zeros [71:67]
);

    logic [15:0] expected_id_reg;
    logic [15:0] expected_seq_reg;
    logic [31:0] send_tick_reg;

    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [5:0]  outer_hdr_reg, outer_hdr_next;
    logic [5:0]  inner_hdr_reg, inner_hdr_next;
    logic [7:0]  kind_reg, kind_next;
    logic [31:0] src_addr_reg, src_addr_next;
    logic [15:0] seen_id_reg, seen_id_next;
    logic [15:0] seen_seq_reg, seen_seq_next;

    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    result_t     res;
    logic        in_fire;
    logic [7:0]  in_byte;
    logic [31:0] tick_now;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] h;
    logic [POS_W-1:0] j;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] outer_len;
    logic [POS_W-1:0] inner_len;

    assign in_fire  = s_tvalid && s_tready;
    assign in_byte  = s_tdata[7:0];
    assign tick_now = s_tdata[39:8];
    assign pos      = byte_pos_reg;
    assign s_tready = !skid_valid_reg;

    // per-byte field capture
    always_comb begin
        byte_pos_next  = byte_pos_reg;
        outer_hdr_next = outer_hdr_reg;
        inner_hdr_next = inner_hdr_reg;
        kind_next      = kind_reg;
        src_addr_next  = src_addr_reg;
        seen_id_next   = seen_id_reg;
        seen_seq_next  = seen_seq_reg;
        h = POS_W'(outer_hdr_reg);
        j = h + ICMP_HDR_LEN + POS_W'(inner_hdr_reg);
        if (pos < POS_W'(MAX_PACKET_BYTES)) begin
            byte_pos_next = pos + POS_W'(1);
            if (pos == '0) begin
                outer_hdr_next = {in_byte[3:0], 2'b00};
            end
            h = POS_W'(outer_hdr_next);
            j = h + ICMP_HDR_LEN + POS_W'(inner_hdr_reg);
            if (pos == POS_W'(12)) src_addr_next[7:0]   = in_byte;
            if (pos == POS_W'(13)) src_addr_next[15:8]  = in_byte;
            if (pos == POS_W'(14)) src_addr_next[23:16] = in_byte;
            if (pos == POS_W'(15)) src_addr_next[31:24] = in_byte;
            if (pos == h) begin
                kind_next = in_byte;
            end else if (pos > h) begin
                if (kind_reg == TYPE_ECHO_REPLY) begin
                    if (pos == h + POS_W'(4)) seen_id_next[7:0]   = in_byte;
                    if (pos == h + POS_W'(5)) seen_id_next[15:8]  = in_byte;
                    if (pos == h + POS_W'(6)) seen_seq_next[7:0]  = in_byte;
                    if (pos == h + POS_W'(7)) seen_seq_next[15:8] = in_byte;
                end else if (kind_reg == TYPE_TIME_EXCEEDED) begin
                    if (pos == h + ICMP_HDR_LEN) begin
                        inner_hdr_next = {in_byte[3:0], 2'b00};
                    end else if (pos > h + ICMP_HDR_LEN) begin
                        if (pos == j + POS_W'(4)) seen_id_next[7:0]   = in_byte;
                        if (pos == j + POS_W'(5)) seen_id_next[15:8]  = in_byte;
                        if (pos == j + POS_W'(6)) seen_seq_next[7:0]  = in_byte;
                        if (pos == j + POS_W'(7)) seen_seq_next[15:8] = in_byte;
                    end
                end
            end
        end
    end

    // end-of-packet verdict
    always_comb begin
        len       = byte_pos_next;
        outer_len = POS_W'(outer_hdr_next);
        inner_len = POS_W'(inner_hdr_next);
        res.source_addr = src_addr_next;
        res.round_trip  = '0;
        if (len < outer_len + ICMP_HDR_LEN) begin
            res.status = ST_TOO_SHORT;
        end else if (kind_next != TYPE_ECHO_REPLY && kind_next != TYPE_TIME_EXCEEDED) begin
            res.status = ST_OTHER_TYPE;
        end else if (kind_next == TYPE_TIME_EXCEEDED &&
                     (len <= outer_len + ICMP_HDR_LEN ||
                      len < outer_len + ICMP_HDR_LEN + inner_len + ICMP_HDR_LEN)) begin
            res.status = ST_INNER_TRUNC;
        end else if (seen_id_next != expected_id_reg || seen_seq_next != expected_seq_reg) begin
            res.status = ST_MISMATCH;
        end else begin
            res.status     = (kind_next == TYPE_ECHO_REPLY) ? ST_ECHO_MATCH : ST_TTL_MATCH;
            res.round_trip = tick_now - send_tick_reg;
        end
    end

    // two-entry output buffer
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (in_fire && s_tlast) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (in_fire && s_tlast) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_id_reg  <= '0;
            expected_seq_reg <= '0;
            send_tick_reg    <= '0;
            byte_pos_reg     <= '0;
            outer_hdr_reg    <= '0;
            inner_hdr_reg    <= '0;
            kind_reg         <= '0;
            src_addr_reg     <= '0;
            seen_id_reg      <= '0;
            seen_seq_reg     <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_EXPECTED_ID:  expected_id_reg  <= cfg_wdata[15:0];
                    CFG_EXPECTED_SEQ: expected_seq_reg <= cfg_wdata[15:0];
                    CFG_SEND_TICK:    send_tick_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
            if (in_fire) begin
                if (s_tlast) begin
                    byte_pos_reg  <= '0;
                    outer_hdr_reg <= '0;
                    inner_hdr_reg <= '0;
                    kind_reg      <= '0;
                    src_addr_reg  <= '0;
                    seen_id_reg   <= '0;
                    seen_seq_reg  <= '0;
                end else begin
                    byte_pos_reg  <= byte_pos_next;
                    outer_hdr_reg <= outer_hdr_next;
                    inner_hdr_reg <= inner_hdr_next;
                    kind_reg      <= kind_next;
                    src_addr_reg  <= src_addr_next;
                    seen_id_reg   <= seen_id_next;
                    seen_seq_reg  <= seen_seq_next;
                end
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg};

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output entry empty");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_pos_reg <= POS_W'(MAX_PACKET_BYTES))
        else $error("byte position past packet limit");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_tlast |=> byte_pos_reg == '0 && kind_reg == '0)
        else $error("packet state not cleared after last byte");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_tlast |=> m_tvalid)
        else $error("no result after last byte");

    a_hdr_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        outer_hdr_reg[1:0] == 2'b00 && inner_hdr_reg[1:0] == 2'b00)
        else $error("header length not a multiple of four");
`endif

endmodule

`default_nettype wire
